### design/rational_arithmetic_unit_defines.svh
// Assertion macros used by the rational arithmetic unit checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
// Same-cycle implication, sampled on the rising clock edge.
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational_arithmetic_unit check failed");
// Next-cycle implication, sampled on the rising clock edge.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational_arithmetic_unit check failed");
`endif

### design/rau_pkg.sv
// Package with shared constants of the rational arithmetic unit.
package rau_pkg;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Control handshake toward the shared divider.
    typedef struct packed {
        logic go;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;
endpackage

### design/rau_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module rau_divider #(
    parameter int W = rau_pkg::WORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::div_req_t  req,
    input  logic [W-2:0]       dividend,
    input  logic [W-2:0]       divisor,
    output rau_pkg::div_rsp_t  rsp,
    output logic [W-2:0]       quotient,
    output logic [W-2:0]       remainder
);
    localparam int CW = $clog2(W);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W-2:0]  quo_reg, quo_next;
    logic [W-2:0]  rem_reg, rem_next;
    logic [W-2:0]  dsr_reg, dsr_next;
    logic [W-1:0]  shifted;
    logic [W-1:0]  diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-2]};
        diff      = shifted - {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.go)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = diff[W-2:0];
                quo_next = {quo_reg[W-3:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-2:0];
                quo_next = {quo_reg[W-3:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

### design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, divider, multiplier and result check.
//
// Usage: a request (opcode, a_num/a_den, b_num/b_den) is taken at a rising
// edge where start is high and busy is low. busy then stays high until the
// result is delivered; no other request is taken meanwhile.
// The result (result_num, result_den, status) is shown for exactly one cycle
// with done high. The receiver cannot stall, so the result must be captured
// in that cycle. A new request may be issued in the cycle done is high.
// A zero input denominator goes straight to the result check. Multiply and
// divide form two products through the one registered multiplier.
// Add and subtract run Euclid's loop on the shared bit-serial divider, one
// division per remainder step, then two more divisions by the gcd and three
// products.
// Status 1 flags a zero denominator, status 2 a result beyond the signed
// word range; the result fields are then zero.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears
// done and busy; no request in flight survives it.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic [1:0]           opcode,
    input  logic [WORD_BITS-1:0] a_num,
    input  logic [WORD_BITS-2:0] a_den,
    input  logic [WORD_BITS-1:0] b_num,
    input  logic [WORD_BITS-2:0] b_den,
    output logic [WORD_BITS-1:0] result_num,
    output logic [WORD_BITS-2:0] result_den,
    output logic [1:0]           status
);
    localparam int W  = WORD_BITS;
    localparam int AW = 2 * W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [1:0] PH_GCD = 2'd0;
    localparam logic [1:0] PH_QA  = 2'd1;
    localparam logic [1:0] PH_QB  = 2'd2;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [1:0]          k_reg, k_next;
    logic                done_reg, done_next;
    logic                zden_reg, zden_next;
    logic [1:0]          op_reg, op_next;
    logic signed [W-1:0] an_reg, an_next, bn_reg, bn_next;
    logic [W-2:0]        ad_reg, ad_next, bd_reg, bd_next;
    logic [W-2:0]        x_reg, x_next, y_reg, y_next;
    logic [W-2:0]        qa_reg, qa_next, qb_reg, qb_next;
    logic signed [2*W-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] num_reg, num_next, den_reg, den_next;
    logic [W-1:0]        rnum_reg, rnum_next;
    logic [W-2:0]        rden_reg, rden_next;
    logic [1:0]          st_reg, st_next;

    rau_pkg::div_req_t   dreq;
    rau_pkg::div_rsp_t   drsp;
    logic [W-2:0]        div_a, div_b, div_q, div_r;

    logic signed [W-1:0] ma, mb;
    logic signed [AW-1:0] prod_ext, nn, dd;
    logic                is_addsub, last_acc, num_ok, den_ok;

    rau_divider #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (dreq),
        .dividend  (div_a),
        .divisor   (div_b),
        .rsp       (drsp),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        is_addsub = (op_reg == rau_pkg::OP_ADD) || (op_reg == rau_pkg::OP_SUB);
        ma = an_reg;
        mb = bn_reg;
        if (is_addsub)
        begin
            case (k_reg)
                2'd0:
                begin
                    ma = an_reg;
                    mb = $signed({1'b0, qb_reg});
                end
                2'd1:
                begin
                    ma = bn_reg;
                    mb = $signed({1'b0, qa_reg});
                end
                default:
                begin
                    ma = $signed({1'b0, qa_reg});
                    mb = $signed({1'b0, bd_reg});
                end
            endcase
        end
        else if (op_reg == rau_pkg::OP_MUL)
        begin
            if (k_reg == 2'd0)
            begin
                ma = an_reg;
                mb = bn_reg;
            end
            else
            begin
                ma = $signed({1'b0, ad_reg});
                mb = $signed({1'b0, bd_reg});
            end
        end
        else
        begin
            if (k_reg == 2'd0)
            begin
                ma = an_reg;
                mb = $signed({1'b0, bd_reg});
            end
            else
            begin
                ma = $signed({1'b0, ad_reg});
                mb = bn_reg;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        zden_next  = zden_reg;
        op_next    = op_reg;
        an_next    = an_reg;
        bn_next    = bn_reg;
        ad_next    = ad_reg;
        bd_next    = bd_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rnum_next  = rnum_reg;
        rden_next  = rden_reg;
        st_next    = st_reg;
        dreq.go    = 1'b0;
        div_a      = x_reg;
        div_b      = y_reg;
        prod_ext   = AW'(prod_reg);
        last_acc   = 1'b0;
        nn         = num_reg;
        dd         = den_reg;
        num_ok     = 1'b0;
        den_ok     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = opcode;
                    an_next = a_num;
                    bn_next = b_num;
                    ad_next = a_den;
                    bd_next = b_den;
                    x_next  = a_den;
                    y_next  = b_den;
                    k_next  = 2'd0;
                    zden_next = (a_den == '0) || (b_den == '0);
                    if ((a_den == '0) || (b_den == '0))
                        state_next = S_FIN;
                    else if ((opcode == rau_pkg::OP_ADD) || (opcode == rau_pkg::OP_SUB))
                        state_next = S_GCD;
                    else
                        state_next = S_MUL;
                end
            end
            S_GCD:
            begin
                dreq.go = 1'b1;
                if (y_reg == '0)
                begin
                    // x now holds the gcd; divide a_den by it first.
                    div_a      = ad_reg;
                    div_b      = x_reg;
                    phase_next = PH_QA;
                end
                else
                begin
                    phase_next = PH_GCD;
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                div_a = bd_reg;
                div_b = x_reg;
                if (drsp.done)
                begin
                    case (phase_reg)
                        PH_GCD:
                        begin
                            x_next     = y_reg;
                            y_next     = div_r;
                            state_next = S_GCD;
                        end
                        PH_QA:
                        begin
                            qa_next    = div_q;
                            dreq.go    = 1'b1;
                            phase_next = PH_QB;
                        end
                        default:
                        begin
                            qb_next    = div_q;
                            k_next     = 2'd0;
                            state_next = S_MUL;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = ma * mb;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                last_acc = is_addsub ? (k_reg == 2'd2) : (k_reg == 2'd1);
                if (k_reg == 2'd0)
                    num_next = prod_ext;
                else if (is_addsub && (k_reg == 2'd1))
                    num_next = (op_reg == rau_pkg::OP_SUB) ? num_reg - prod_ext
                                                           : num_reg + prod_ext;
                else
                    den_next = prod_ext;
                if (last_acc)
                    state_next = S_FIN;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                // Move the sign to the numerator, then range-check both parts.
                if (den_reg < 0)
                begin
                    nn = -num_reg;
                    dd = -den_reg;
                end
                num_ok = (nn[AW-1:W-1] == '0) || (nn[AW-1:W-1] == '1);
                den_ok = (dd[AW-1:W-1] == '0);
                rnum_next = '0;
                rden_next = '0;
                if (zden_reg || (den_reg == '0))
                    st_next = rau_pkg::ST_ZERO_DEN;
                else if (!num_ok || !den_ok)
                    st_next = rau_pkg::ST_OVERFLOW;
                else
                begin
                    st_next   = rau_pkg::ST_OK;
                    rnum_next = nn[W-1:0];
                    rden_next = dd[W-2:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_GCD;
            k_reg     <= 2'd0;
            done_reg  <= 1'b0;
            zden_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
            zden_reg  <= zden_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        an_reg   <= an_next;
        bn_reg   <= bn_next;
        ad_reg   <= ad_next;
        bd_reg   <= bd_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
        st_reg   <= st_next;
    end

    assign busy       = (state_reg != S_IDLE) || drsp.busy;
    assign done       = done_reg;
    assign result_num = rnum_reg;
    assign result_den = rden_reg;
    assign status     = st_reg;
endmodule

### design/rau_checker.sv
// Port-level checker for the rational arithmetic unit, with its bind.
`include "rational_arithmetic_unit_defines.svh"
module rau_checker #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [WORD_BITS-1:0] result_num,
    input logic [WORD_BITS-2:0] result_den,
    input logic [1:0]           status
);
    // A result is a single-cycle pulse.
    `RAU_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // An accepted request keeps the unit busy in the following cycle.
    `RAU_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
    // Results never appear while a request is still being worked on.
    `RAU_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    // An error status carries a zero fraction.
    `RAU_ASSERT_NOW(a_err_zero, clk, rst_n, done && (status != rau_pkg::ST_OK),
        (result_num == '0) && (result_den == '0))
endmodule

bind rational_arithmetic_unit rau_checker #(.WORD_BITS(WORD_BITS)) u_rau_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .result_num (result_num),
    .result_den (result_den),
    .status     (status)
);
